FILE: sv/ecpr_pkg.sv
`timescale 1ns / 1ps

package ecpr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 12;
    localparam int FAULT_W       = 16;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        OP_HIT,
        OP_FILL,
        OP_VICTIM
    } upd_op_t;

    typedef enum logic [1:0] {
        CLR_NONE,
        CLR_BELOW,
        CLR_ALL
    } clr_mode_t;

    // Flags that ride along with an access as it walks the frame chain
    typedef struct packed {
        logic vld;
        logic wr;
        logic hit_f;
        logic a_f;   // first frame with use 0, dirty 0 seen
        logic b_f;   // first frame with use 0, dirty 1 seen
        logic c_f;   // first clean frame seen
    } tok_flags_t;

    // Broadcast update applied to all frames at the end of an access
    typedef struct packed {
        logic      en;
        upd_op_t   op;
        clr_mode_t clr;
        logic      wr;
    } upd_ctl_t;

endpackage

FILE: sv/enhanced_clock_page_replacement_core.sv
`timescale 1ns / 1ps

// Enhanced second-chance (clock) page replacement over FRAMES frames.
// Input channel: in_valid / in_stall carries one page access (page, is_write)
// per transaction. Output channel: out_valid / out_stall carries one result
// per access: hit, frame, evicted_valid, evicted_page, evicted_dirty and the
// saturating fault_count after the access.
// Each frame is one cell of a chain; an accepted access walks the chain one
// frame per cycle, collecting the hit match and the victim candidates, then
// the commit updates all frames at once and loads the output register.
// Only one access is in flight at a time: the next access is accepted only
// after the previous one has walked the frame chain and committed.
// in_stall is low only while the block is idle. A result waiting under
// out_stall does not block the next access; that access waits in its commit
// cycle until the output register frees up.
// Reset clears use and dirty bits, the fill count, the fault count, out_valid
// and the chain's token flags; frame tags are written before they are read.
module enhanced_clock_page_replacement_core
    import ecpr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    localparam int IW       = (FRAMES > 1) ? $clog2(FRAMES) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PAGE_BITS-1:0] page,
    input  logic                 is_write,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic [IW-1:0]        frame,
    output logic                 evicted_valid,
    output logic [PAGE_BITS-1:0] evicted_page,
    output logic                 evicted_dirty,
    output logic [FAULT_W-1:0]   fault_count
);

    localparam int FW = $clog2(FRAMES + 1);
    localparam logic [FW-1:0] FULL = FW'(FRAMES);

    ctl_state_t           state_reg, state_next;
    logic [FW-1:0]        filled_reg, filled_next;
    logic [FAULT_W-1:0]   faults_reg, faults_next;
    logic                 accept;
    logic                 commit;

    tok_flags_t           flg_c  [FRAMES+1];
    logic [PAGE_BITS-1:0] page_c [FRAMES+1];
    logic [IW-1:0]        hidx_c [FRAMES+1];
    logic [IW-1:0]        aidx_c [FRAMES+1];
    logic [IW-1:0]        bidx_c [FRAMES+1];
    logic [IW-1:0]        cidx_c [FRAMES+1];
    logic [PAGE_BITS-1:0] atag_c [FRAMES+1];
    logic [PAGE_BITS-1:0] btag_c [FRAMES+1];
    logic [PAGE_BITS-1:0] ctag_c [FRAMES+1];
    logic [FRAMES-1:0]    live;
    logic [FRAMES-1:0]    tok_vld;

    tok_flags_t           fin_flg_reg;
    logic [PAGE_BITS-1:0] fin_page_reg;
    logic [IW-1:0]        fin_hidx_reg, fin_aidx_reg, fin_bidx_reg, fin_cidx_reg;
    logic [PAGE_BITS-1:0] fin_atag_reg, fin_btag_reg, fin_ctag_reg;

    upd_ctl_t             upd;
    logic [IW-1:0]        upd_idx;

    logic                 out_valid_reg;
    logic                 hit_reg, hit_next;
    logic [IW-1:0]        frame_reg, frame_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [PAGE_BITS-1:0] ev_page_reg, ev_page_next;
    logic                 ev_dirty_reg, ev_dirty_next;

    assign accept = in_valid && !in_stall;

    // Head of the chain: a fresh transaction with nothing found yet
    always_comb
    begin
        flg_c[0]       = '0;
        flg_c[0].vld   = accept;
        flg_c[0].wr    = is_write;
        page_c[0]      = page;
        hidx_c[0]      = '0;
        aidx_c[0]      = '0;
        bidx_c[0]      = '0;
        cidx_c[0]      = '0;
        atag_c[0]      = '0;
        btag_c[0]      = '0;
        ctag_c[0]      = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < FRAMES; gi++)
        begin : g_cell
            assign live[gi]    = FW'(gi) < filled_reg;
            assign tok_vld[gi] = flg_c[gi+1].vld;

            ecpr_cell #(
                .FRAMES    (FRAMES),
                .PAGE_BITS (PAGE_BITS),
                .IDX       (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .live     (live[gi]),
                .flg_in   (flg_c[gi]),
                .page_in  (page_c[gi]),
                .hidx_in  (hidx_c[gi]),
                .aidx_in  (aidx_c[gi]),
                .bidx_in  (bidx_c[gi]),
                .cidx_in  (cidx_c[gi]),
                .atag_in  (atag_c[gi]),
                .btag_in  (btag_c[gi]),
                .ctag_in  (ctag_c[gi]),
                .flg_out  (flg_c[gi+1]),
                .page_out (page_c[gi+1]),
                .hidx_out (hidx_c[gi+1]),
                .aidx_out (aidx_c[gi+1]),
                .bidx_out (bidx_c[gi+1]),
                .cidx_out (cidx_c[gi+1]),
                .atag_out (atag_c[gi+1]),
                .btag_out (btag_c[gi+1]),
                .ctag_out (ctag_c[gi+1]),
                .upd      (upd),
                .upd_idx  (upd_idx),
                .upd_page (fin_page_reg)
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        in_stall      = 1'b1;
        commit        = 1'b0;
        filled_next   = filled_reg;
        faults_next   = faults_reg;
        upd.en        = 1'b0;
        upd.op        = OP_HIT;
        upd.clr       = CLR_NONE;
        upd.wr        = fin_flg_reg.wr;
        upd_idx       = fin_hidx_reg;
        hit_next      = 1'b0;
        frame_next    = fin_hidx_reg;
        ev_valid_next = 1'b0;
        ev_page_next  = '0;
        ev_dirty_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (flg_c[FRAMES].vld)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    commit     = 1'b1;
                    upd.en     = 1'b1;
                    state_next = ST_IDLE;
                    if (fin_flg_reg.hit_f)
                        hit_next = 1'b1;
                    else if (filled_reg != FULL)
                    begin
                        upd.op      = OP_FILL;
                        upd_idx     = filled_reg[IW-1:0];
                        filled_next = filled_reg + FW'(1);
                    end
                    else
                    begin
                        upd.op        = OP_VICTIM;
                        ev_valid_next = 1'b1;
                        if (faults_reg != FAULT_MAX)
                            faults_next = faults_reg + FAULT_W'(1);
                        // Order: clean unused, dirty unused, first clean, else frame 0
                        if (fin_flg_reg.a_f)
                        begin
                            upd_idx      = fin_aidx_reg;
                            ev_page_next = fin_atag_reg;
                        end
                        else if (fin_flg_reg.b_f)
                        begin
                            upd.clr       = CLR_BELOW;
                            upd_idx       = fin_bidx_reg;
                            ev_page_next  = fin_btag_reg;
                            ev_dirty_next = 1'b1;
                        end
                        else
                        begin
                            upd.clr       = CLR_ALL;
                            upd_idx       = fin_cidx_reg;
                            ev_page_next  = fin_ctag_reg;
                            ev_dirty_next = !fin_flg_reg.c_f;
                        end
                    end
                    frame_next = upd_idx;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filled_reg    <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
            faults_reg <= faults_next;
            if (commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        // Hold the finished walk until the commit cycle
        if ((state_reg == ST_SCAN) && flg_c[FRAMES].vld)
        begin
            fin_flg_reg  <= flg_c[FRAMES];
            fin_page_reg <= page_c[FRAMES];
            fin_hidx_reg <= hidx_c[FRAMES];
            fin_aidx_reg <= aidx_c[FRAMES];
            fin_bidx_reg <= bidx_c[FRAMES];
            fin_cidx_reg <= cidx_c[FRAMES];
            fin_atag_reg <= atag_c[FRAMES];
            fin_btag_reg <= btag_c[FRAMES];
            fin_ctag_reg <= ctag_c[FRAMES];
        end
        if (commit)
        begin
            hit_reg      <= hit_next;
            frame_reg    <= frame_next;
            ev_valid_reg <= ev_valid_next;
            ev_page_reg  <= ev_page_next;
            ev_dirty_reg <= ev_dirty_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame         = frame_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign evicted_dirty = ev_dirty_reg;
    assign fault_count   = faults_reg;

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN))
        else $error("accepted transaction did not start a scan");

    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one access in the frame chain");

    a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (|tok_vld) |-> (state_reg == ST_SCAN))
        else $error("access in the frame chain outside of scan");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FULL)
        else $error("fill count beyond frame count");

    a_evict_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted_valid) |-> (filled_reg == FULL))
        else $error("eviction reported before all frames filled");

endmodule

FILE: sv/ecpr_cell.sv
`timescale 1ns / 1ps

module ecpr_cell
    import ecpr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int IDX       = 0,
    localparam int IW       = (FRAMES > 1) ? $clog2(FRAMES) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 live,
    input  tok_flags_t           flg_in,
    input  logic [PAGE_BITS-1:0] page_in,
    input  logic [IW-1:0]        hidx_in,
    input  logic [IW-1:0]        aidx_in,
    input  logic [IW-1:0]        bidx_in,
    input  logic [IW-1:0]        cidx_in,
    input  logic [PAGE_BITS-1:0] atag_in,
    input  logic [PAGE_BITS-1:0] btag_in,
    input  logic [PAGE_BITS-1:0] ctag_in,
    output tok_flags_t           flg_out,
    output logic [PAGE_BITS-1:0] page_out,
    output logic [IW-1:0]        hidx_out,
    output logic [IW-1:0]        aidx_out,
    output logic [IW-1:0]        bidx_out,
    output logic [IW-1:0]        cidx_out,
    output logic [PAGE_BITS-1:0] atag_out,
    output logic [PAGE_BITS-1:0] btag_out,
    output logic [PAGE_BITS-1:0] ctag_out,
    input  upd_ctl_t             upd,
    input  logic [IW-1:0]        upd_idx,
    input  logic [PAGE_BITS-1:0] upd_page
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [PAGE_BITS-1:0] tag_reg, tag_next;
    logic                 use_reg, use_next;
    logic                 dirty_reg, dirty_next;

    tok_flags_t           flg_reg, flg_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic [IW-1:0]        hidx_reg, hidx_next;
    logic [IW-1:0]        aidx_reg, aidx_next;
    logic [IW-1:0]        bidx_reg, bidx_next;
    logic [IW-1:0]        cidx_reg, cidx_next;
    logic [PAGE_BITS-1:0] atag_reg, atag_next;
    logic [PAGE_BITS-1:0] btag_reg, btag_next;
    logic [PAGE_BITS-1:0] ctag_reg, ctag_next;

    // Classify this frame for the passing transaction
    always_comb
    begin
        flg_next  = flg_in;
        hidx_next = hidx_in;
        aidx_next = aidx_in;
        bidx_next = bidx_in;
        cidx_next = cidx_in;
        atag_next = atag_in;
        btag_next = btag_in;
        ctag_next = ctag_in;
        if (!flg_in.hit_f && live && (tag_reg == page_in))
        begin
            flg_next.hit_f = 1'b1;
            hidx_next      = MY_IDX;
        end
        if (!flg_in.a_f && !use_reg && !dirty_reg)
        begin
            flg_next.a_f = 1'b1;
            aidx_next    = MY_IDX;
            atag_next    = tag_reg;
        end
        if (!flg_in.b_f && !use_reg && dirty_reg)
        begin
            flg_next.b_f = 1'b1;
            bidx_next    = MY_IDX;
            btag_next    = tag_reg;
        end
        // frame 0 stands in as the fallback victim when every frame is dirty
        if (!flg_in.c_f && (!dirty_reg || (IDX == 0)))
        begin
            flg_next.c_f = !dirty_reg;
            cidx_next    = MY_IDX;
            ctag_next    = tag_reg;
        end
    end

    always_comb
    begin
        tag_next   = tag_reg;
        use_next   = use_reg;
        dirty_next = dirty_reg;
        if (upd.en)
        begin
            if ((upd.clr == CLR_ALL) || ((upd.clr == CLR_BELOW) && (MY_IDX < upd_idx)))
                use_next = 1'b0;
            if (upd_idx == MY_IDX)
            begin
                use_next = 1'b1;
                if (upd.op == OP_HIT)
                    dirty_next = dirty_reg | upd.wr;
                else
                begin
                    tag_next   = upd_page;
                    dirty_next = upd.wr;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg   <= 1'b0;
            dirty_reg <= 1'b0;
            flg_reg   <= '0;
        end
        else
        begin
            use_reg   <= use_next;
            dirty_reg <= dirty_next;
            flg_reg   <= flg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        page_reg <= page_in;
        hidx_reg <= hidx_next;
        aidx_reg <= aidx_next;
        bidx_reg <= bidx_next;
        cidx_reg <= cidx_next;
        atag_reg <= atag_next;
        btag_reg <= btag_next;
        ctag_reg <= ctag_next;
    end

    assign flg_out  = flg_reg;
    assign page_out = page_reg;
    assign hidx_out = hidx_reg;
    assign aidx_out = aidx_reg;
    assign bidx_out = bidx_reg;
    assign cidx_out = cidx_reg;
    assign atag_out = atag_reg;
    assign btag_out = btag_reg;
    assign ctag_out = ctag_reg;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import ecpr_pkg::*;

    localparam int FRAMES      = FRAMES_DEF;
    localparam int PAGE_BITS   = PAGE_BITS_DEF;
    localparam int IW          = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int WALK_CYCLES = FRAMES + 2;
    localparam int POOL_SIZE   = 12;

    typedef struct {
        logic                 hit;
        logic [IW-1:0]        frame;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic                 evicted_dirty;
        logic [FAULT_W-1:0]   fault_count;
    } access_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [PAGE_BITS-1:0] page;
    logic                 is_write;
    logic                 out_valid;
    logic                 out_stall;
    logic                 hit;
    logic [IW-1:0]        frame;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic                 evicted_dirty;
    logic [FAULT_W-1:0]   fault_count;

    // Shadow copy of the frame table
    logic [PAGE_BITS-1:0] tag_model   [FRAMES];
    logic                 use_model   [FRAMES];
    logic                 dirty_model [FRAMES];
    int                   filled_model;
    logic [FAULT_W-1:0]   faults_model;

    access_result_t pending_results[$];

    int src_idle_pct;
    int sink_idle_pct;
    int mismatches;
    int accesses_sent;
    int results_checked;
    int hits_seen;
    int fills_seen;
    int replacements_seen;
    int dirty_evictions;

    enhanced_clock_page_replacement_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page          (page),
        .is_write      (is_write),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame         (frame),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .evicted_dirty (evicted_dirty),
        .fault_count   (fault_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Even passes take a clean unused frame; odd passes take a dirty unused
    // frame and clear use bits as they sweep past.
    function automatic int choose_victim();
        int f;
        bit odd;
        for (int s = 0; s < 4 * FRAMES; s++)
        begin
            f   = s % FRAMES;
            odd = ((s / FRAMES) % 2) == 1;
            if (!odd)
            begin
                if (!use_model[f] && !dirty_model[f])
                    return f;
            end
            else
            begin
                if (!use_model[f] && dirty_model[f])
                    return f;
                use_model[f] = 1'b0;
            end
        end
        return 0;
    endfunction

    function automatic access_result_t predict_access(logic [PAGE_BITS-1:0] pg, logic wr);
        access_result_t r;
        upd_op_t        op;
        int             fr;
        r  = '{default: '0};
        fr = 0;
        op = (filled_model < FRAMES) ? OP_FILL : OP_VICTIM;
        for (int i = 0; i < filled_model; i++)
        begin
            if (tag_model[i] == pg)
            begin
                op = OP_HIT;
                fr = i;
                break;
            end
        end
        case (op)
            OP_HIT:
            begin
                use_model[fr] = 1'b1;
                if (wr)
                    dirty_model[fr] = 1'b1;
                hits_seen++;
            end
            OP_FILL:
            begin
                fr              = filled_model;
                tag_model[fr]   = pg;
                use_model[fr]   = 1'b1;
                dirty_model[fr] = wr;
                filled_model++;
                fills_seen++;
            end
            default:
            begin
                if (faults_model != FAULT_MAX)
                    faults_model++;
                fr              = choose_victim();
                r.evicted_valid = 1'b1;
                r.evicted_page  = tag_model[fr];
                r.evicted_dirty = dirty_model[fr];
                tag_model[fr]   = pg;
                use_model[fr]   = 1'b1;
                dirty_model[fr] = wr;
                replacements_seen++;
                if (r.evicted_dirty)
                    dirty_evictions++;
            end
        endcase
        r.hit         = (op == OP_HIT);
        r.frame       = IW'(fr);
        r.fault_count = faults_model;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want_v);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want_v);
        mismatches++;
    endtask

    // Call right after a rising edge; returns at the edge that takes the transaction.
    task automatic send_access(input logic [PAGE_BITS-1:0] pg, input logic wr);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        page     <= pg;
        is_write <= wr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_access(pg, wr));
        accesses_sent++;
    endtask

    task automatic wait_results_done();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_results.size() != 0)
            report_mismatch("results missing", pending_results.size(), 0);
        repeat (2 * WALK_CYCLES) @(posedge clk);
    endtask

    // Checker: compare each result transaction with the oldest prediction.
    initial
    begin
        access_result_t want;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result, frame", frame, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (hit !== want.hit)
                        report_mismatch("hit", hit, want.hit);
                    if (frame !== want.frame)
                        report_mismatch("frame", frame, want.frame);
                    if (evicted_valid !== want.evicted_valid)
                        report_mismatch("evicted_valid", evicted_valid, want.evicted_valid);
                    if (evicted_page !== want.evicted_page)
                        report_mismatch("evicted_page", evicted_page, want.evicted_page);
                    if (evicted_dirty !== want.evicted_dirty)
                        report_mismatch("evicted_dirty", evicted_dirty, want.evicted_dirty);
                    if (fault_count !== want.fault_count)
                        report_mismatch("fault_count", fault_count, want.fault_count);
                    results_checked++;
                end
            end
            out_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // Page 0 first: unwritten tags must never match. Then fill, read and write hits.
    task automatic test_cold_fill();
        send_access(12'h000, 1'b0);
        send_access(12'hFFF, 1'b1);
        send_access(12'h000, 1'b1);
        send_access(12'hFFF, 1'b0);
        send_access(12'h800, 1'b0);
        send_access(12'h555, 1'b1);
        send_access(12'hAAA, 1'b0);
        send_access(12'h001, 1'b1);
        send_access(12'h7FF, 1'b0);
        send_access(12'h123, 1'b0);
        send_access(12'h555, 1'b0);
    endtask

    // Full table: first miss sweeps all use bits away; then make every frame
    // dirty so the search has to run into its last pass.
    task automatic test_victim_search();
        send_access(12'h400, 1'b0);
        for (int k = 0; k < FRAMES; k++)
            send_access(PAGE_BITS'(12'h900 + k), 1'b1);
        send_access(12'h0F0, 1'b0);
        send_access(12'h0F1, 1'b0);
        send_access(12'h0F0, 1'b1);
    endtask

    task automatic test_random_traffic(input int count, input bit pause_midway);
        logic [PAGE_BITS-1:0] pool [POOL_SIZE];
        logic [PAGE_BITS-1:0] pg;
        int                   active;
        active = $urandom_range(POOL_SIZE, 6);
        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = PAGE_BITS'($urandom);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 5)
                pool[$urandom_range(active - 1)] = PAGE_BITS'($urandom);
            if ($urandom_range(99) < 85)
                pg = pool[$urandom_range(active - 1)];
            else
                pg = PAGE_BITS'($urandom);
            send_access(pg, $urandom_range(99) < 40);
            // hold off new transactions until the pipe is empty
            if (pause_midway && n == count / 2)
                wait_results_done();
        end
    endtask

    // Stream of fresh pages back to back, so nearly every access replaces a frame.
    task automatic test_miss_stream(input int count);
        logic [PAGE_BITS-1:0] next_page;
        next_page = PAGE_BITS'($urandom);
        for (int n = 0; n < count; n++)
        begin
            send_access(next_page, 1'($urandom_range(1)));
            next_page++;
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        page     <= '0;
        is_write <= 1'b0;
        for (int i = 0; i < FRAMES; i++)
        begin
            tag_model[i]   = '0;
            use_model[i]   = 1'b0;
            dirty_model[i] = 1'b0;
        end
        filled_model      = 0;
        faults_model      = '0;
        mismatches        = 0;
        accesses_sent     = 0;
        results_checked   = 0;
        hits_seen         = 0;
        fills_seen        = 0;
        replacements_seen = 0;
        dirty_evictions   = 0;
        src_idle_pct      = 16;
        sink_idle_pct     = 54;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cold_fill();
        test_victim_search();
        test_random_traffic(280, 1'b1);
        wait_results_done();

        src_idle_pct  = 54;
        sink_idle_pct = 16;
        test_random_traffic(280, 1'b0);
        wait_results_done();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(260, 1'b0);
        test_miss_stream(30);
        wait_results_done();

        $display("Ran %0d page accesses, %0d results checked: %0d hits, %0d fills, %0d replacements",
                 accesses_sent, results_checked, hits_seen, fills_seen, replacements_seen);
        $display("Dirty evictions: %0d, final fault count 0x%0h", dirty_evictions, faults_model);
        if (mismatches == 0)
            $display("enhanced_clock_page_replacement_core verification clean");
        else
            $display("enhanced_clock_page_replacement_core verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout waiting for the run to complete");
        $display("enhanced_clock_page_replacement_core verification failed");
        $finish;
    end

endmodule
